FILE: rtl/qrmask_pkg.sv
package qrmask_pkg;

    // Field widths
    localparam int unsigned COORD_W   = 8;
    localparam int unsigned MODULE_W  = 2;
    localparam int unsigned VERSION_W = 6;
    localparam int unsigned MASK_W    = 3;
    localparam int unsigned SIDE_W    = 9;   // 4*63+17 = 269 fits in 9 bits
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QR_VERSION   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_PATTERN = 1'd1;

    // Register reset values
    localparam logic [VERSION_W-1:0] VERSION_RST = 6'd1;
    localparam logic [MASK_W-1:0]    MASK_RST    = 3'd0;

    // Symbol geometry
    localparam logic [SIDE_W-1:0]  GRID_BASE     = 9'd17;
    localparam logic [SIDE_W-1:0]  FINDER_SPAN   = 9'd9;
    localparam logic [SIDE_W-1:0]  FINDER_OFF    = 9'd8;
    localparam logic [SIDE_W-1:0]  VINFO_LO_OFF  = 9'd11;
    localparam logic [SIDE_W-1:0]  VINFO_HI_OFF  = 9'd9;
    localparam logic [SIDE_W-1:0]  VINFO_SPAN    = 9'd6;
    localparam logic [COORD_W-1:0] TIMING_LINE   = 8'd6;
    localparam logic [VERSION_W-1:0] VINFO_MIN_VER = 6'd7;

    // Stored module codes
    localparam logic [MODULE_W-1:0] MOD_FIRST_RESERVED = 2'd2;

    // Mask formulas
    typedef enum logic [MASK_W-1:0] {
        MASK_SUM_MOD2     = 3'd0,
        MASK_ROW_MOD2     = 3'd1,
        MASK_COL_MOD3     = 3'd2,
        MASK_SUM_MOD3     = 3'd3,
        MASK_BLOCK        = 3'd4,
        MASK_PROD_SUM     = 3'd5,
        MASK_PROD_PARITY  = 3'd6,
        MASK_MIXED_PARITY = 3'd7
    } t_mask_sel;

    // x / 3 for 8-bit x: (x * 171) >> 9 is exact over 0..255, quotient fits 7 bits
    function automatic logic [COORD_W-1:0] div3(input logic [COORD_W-1:0] x);
        logic [15:0] prod;
        prod = 16'(x) * 16'd171;
        return {1'b0, prod[15:9]};
    endfunction

    function automatic logic [1:0] mod3(input logic [COORD_W-1:0] x);
        logic [COORD_W-1:0] q;
        logic [9:0]         r;
        q = div3(x);
        r = 10'(x) - 10'(q) * 10'd3;
        return r[1:0];
    endfunction

    // Reduce a value in 0..4 modulo 3
    function automatic logic [1:0] mod3_small(input logic [2:0] x);
        logic [2:0] r;
        r = (x >= 3'd3) ? (x - 3'd3) : x;
        return r[1:0];
    endfunction

endpackage

FILE: rtl/qr_data_mask_apply.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-------------------------------
// in        | input     | i_in_valid / o_in_stall  | i_row, i_col, i_module_in
// out       | output    | o_out_valid / i_out_stall | o_module_out, o_was_masked
// cfg       | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One module per cycle while the output is not stalled; a module reaches the output
// through the input register, then the result register (the decision logic sits between).
// Reset (i_rst_n low at a clock edge) empties both stages and loads version 1, mask 0.
// A stall on the output holds the result register; the input register keeps filling
// until both stages are full, then o_in_stall is raised in the same cycle.
// The config port is always ready; writes are expected only while the block is idle.
module qr_data_mask_apply
    import qrmask_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [COORD_W-1:0]   i_row,
    input  logic [COORD_W-1:0]   i_col,
    input  logic [MODULE_W-1:0]  i_module_in,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [MODULE_W-1:0]  o_module_out,
    output logic                 o_was_masked,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [VERSION_W-1:0] r_version;
    logic [MASK_W-1:0]    r_mask;

    // Input stage
    logic                r_in_valid;
    logic [COORD_W-1:0]  r_row;
    logic [COORD_W-1:0]  r_col;
    logic [MODULE_W-1:0] r_mod;

    // Result stage
    logic                r_out_valid;
    logic [MODULE_W-1:0] r_mod_out;
    logic                r_masked;
    logic [MODULE_W-1:0] n_mod_out;
    logic                n_masked;

    logic out_load;   // result register free to take the input stage
    logic in_load;    // input register free to take a transaction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= VERSION_RST;
            r_mask    <= MASK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_QR_VERSION:   r_version <= i_cfg_data[VERSION_W-1:0];
                CFG_MASK_PATTERN: r_mask    <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Two-stage flow control
    assign out_load   = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_row <= i_row;
            r_col <= i_col;
            r_mod <= i_module_in;
        end
    end

    // --- Data-module decision ---
    logic [SIDE_W-1:0] side;
    logic [SIDE_W-1:0] row_x;
    logic [SIDE_W-1:0] col_x;
    logic              outside;
    logic              finder;
    logic              vinfo;
    logic              reserved;
    logic              timing;
    logic              is_data;

    assign side  = {1'b0, r_version, 2'b00} + GRID_BASE;
    assign row_x = {1'b0, r_row};
    assign col_x = {1'b0, r_col};

    assign outside = (row_x >= side) || (col_x >= side);

    // Top-left, bottom-left and top-right finder areas (top-left covers format info)
    assign finder = ((row_x < FINDER_SPAN) && (col_x < FINDER_SPAN))
                 || ((row_x >= side - FINDER_OFF) && (col_x < FINDER_SPAN))
                 || ((row_x < FINDER_SPAN) && (col_x >= side - FINDER_OFF));

    // Version information blocks, present from version 7 on
    assign vinfo = (r_version >= VINFO_MIN_VER)
                && (((row_x < VINFO_SPAN) && (col_x >= side - VINFO_LO_OFF)
                                          && (col_x <= side - VINFO_HI_OFF))
                 || ((row_x >= side - VINFO_LO_OFF) && (row_x <= side - VINFO_HI_OFF)
                                          && (col_x < VINFO_SPAN)));

    assign reserved = (r_mod >= MOD_FIRST_RESERVED);
    assign timing   = (r_row == TIMING_LINE) || (r_col == TIMING_LINE);
    assign is_data  = !(outside || finder || vinfo || reserved || timing);

    // --- Mask formula ---
    // Residues only: i mod 3 and j mod 3 set both (i+j) mod 3 and (i*j) mod 3.
    logic [1:0]         row_m3;
    logic [1:0]         col_m3;
    logic [1:0]         sum_m3;
    logic [1:0]         prod_m3;
    logic [3:0]         prod_small;
    logic               sum_m2;
    logic               prod_m2;
    logic [COORD_W-1:0] col_d3;
    logic               mask_hit;

    assign row_m3     = mod3(r_row);
    assign col_m3     = mod3(r_col);
    assign sum_m3     = mod3_small(3'(row_m3) + 3'(col_m3));
    assign prod_small = 4'(row_m3) * 4'(col_m3);
    assign prod_m3    = mod3_small(prod_small[2:0]);
    assign sum_m2     = r_row[0] ^ r_col[0];
    assign prod_m2    = r_row[0] & r_col[0];
    assign col_d3     = div3(r_col);

    always_comb begin
        case (t_mask_sel'(r_mask))
            MASK_SUM_MOD2:     mask_hit = !sum_m2;
            MASK_ROW_MOD2:     mask_hit = !r_row[0];
            MASK_COL_MOD3:     mask_hit = (col_m3 == 2'd0);
            MASK_SUM_MOD3:     mask_hit = (sum_m3 == 2'd0);
            // (i/2 + j/3) mod 2 is the parity of the two low quotient bits
            MASK_BLOCK:        mask_hit = !(r_row[1] ^ col_d3[0]);
            MASK_PROD_SUM:     mask_hit = !prod_m2 && (prod_m3 == 2'd0);
            MASK_PROD_PARITY:  mask_hit = !(prod_m2 ^ prod_m3[0]);
            MASK_MIXED_PARITY: mask_hit = !(sum_m2 ^ prod_m3[0]);
            default:           mask_hit = 1'b0;
        endcase
    end

    // A data module holds 0 or 1, so inversion only flips the low bit
    always_comb begin
        n_masked  = is_data && mask_hit;
        n_mod_out = n_masked ? {1'b0, ~r_mod[0]} : r_mod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_mod_out <= n_mod_out;
            r_masked  <= n_masked;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_module_out = r_mod_out;
    assign o_was_masked = r_masked;

endmodule

FILE: tb/sv/qr_data_mask_apply_checker.sv
`timescale 1ns / 1ps

// Watches the in, out and cfg channels of qr_data_mask_apply, predicts every
// module transaction and compares it with the output transactions in order.
module qr_data_mask_apply_checker
    import qrmask_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  logic [COORD_W-1:0]   i_row,
    input  logic [COORD_W-1:0]   i_col,
    input  logic [MODULE_W-1:0]  i_module_in,

    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  logic [MODULE_W-1:0]  o_module_out,
    input  logic                 o_was_masked,

    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,

    input  logic                 i_final_check,
    output int unsigned          o_pending,
    output int unsigned          o_mismatch_count
);

    typedef struct packed {
        logic [MODULE_W-1:0] module_out;
        logic                was_masked;
    } masked_module_t;

    masked_module_t       expected_modules[$];
    masked_module_t       want;
    logic [VERSION_W-1:0] version_q;
    logic [MASK_W-1:0]    mask_q;
    int unsigned          result_count;
    bit                   final_done;

    initial begin
        o_pending        = 0;
        o_mismatch_count = 0;
        result_count     = 0;
        final_done       = 1'b0;
        version_q        = VERSION_RST;
        mask_q           = MASK_RST;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        o_mismatch_count++;
    endtask

    // Data-module test plus the selected mask formula at the current setting
    function automatic masked_module_t predict_module(input logic [COORD_W-1:0] row,
                                                      input logic [COORD_W-1:0] col,
                                                      input logic [MODULE_W-1:0] mod_in);
        int unsigned    side, i, j, prod;
        bit             is_data, flip;
        masked_module_t res;
        side    = 4 * version_q + GRID_BASE;
        i       = row;
        j       = col;
        prod    = i * j;
        is_data = 1'b1;
        if (i >= side || j >= side)
            is_data = 1'b0;
        if (i < FINDER_SPAN && j < FINDER_SPAN)
            is_data = 1'b0;
        if (i >= side - FINDER_OFF && j < FINDER_SPAN)
            is_data = 1'b0;
        if (i < FINDER_SPAN && j >= side - FINDER_OFF)
            is_data = 1'b0;
        if (version_q >= VINFO_MIN_VER) begin
            if (i < VINFO_SPAN && j >= side - VINFO_LO_OFF && j <= side - VINFO_HI_OFF)
                is_data = 1'b0;
            if (i >= side - VINFO_LO_OFF && i <= side - VINFO_HI_OFF && j < VINFO_SPAN)
                is_data = 1'b0;
        end
        if (mod_in >= MOD_FIRST_RESERVED)
            is_data = 1'b0;
        if (i == TIMING_LINE || j == TIMING_LINE)
            is_data = 1'b0;
        case (t_mask_sel'(mask_q))
            MASK_SUM_MOD2:     flip = ((i + j) % 2) == 0;
            MASK_ROW_MOD2:     flip = (i % 2) == 0;
            MASK_COL_MOD3:     flip = (j % 3) == 0;
            MASK_SUM_MOD3:     flip = ((i + j) % 3) == 0;
            MASK_BLOCK:        flip = ((i / 2 + j / 3) % 2) == 0;
            MASK_PROD_SUM:     flip = (prod % 2 + prod % 3) == 0;
            MASK_PROD_PARITY:  flip = ((prod % 2 + prod % 3) % 2) == 0;
            default:           flip = (((i + j) % 2 + prod % 3) % 2) == 0;
        endcase
        res.was_masked = is_data && flip;
        // data modules hold 0 or 1 only, so inversion is a flip of bit 0
        res.module_out = res.was_masked ? {1'b0, ~mod_in[0]} : mod_in;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            version_q = VERSION_RST;
            mask_q    = MASK_RST;
            expected_modules.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_QR_VERSION:   version_q = i_cfg_data[VERSION_W-1:0];
                    CFG_MASK_PATTERN: mask_q    = i_cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_modules.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d: module_out=%0d masked=%0d",
                                              result_count, o_module_out, o_was_masked));
                end else begin
                    want = expected_modules.pop_front();
                    if (o_module_out !== want.module_out)
                        report_mismatch($sformatf("result %0d module_out: got %0d want %0d",
                                                  result_count, o_module_out, want.module_out));
                    if (o_was_masked !== want.was_masked)
                        report_mismatch($sformatf("result %0d was_masked: got %0d want %0d",
                                                  result_count, o_was_masked, want.was_masked));
                end
                result_count++;
            end
            if (i_in_valid && !o_in_stall)
                expected_modules.push_back(predict_module(i_row, i_col, i_module_in));
            if (i_final_check && !final_done) begin
                final_done = 1'b1;
                if (expected_modules.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived",
                                              expected_modules.size()));
            end
        end
        o_pending = expected_modules.size();
    end

endmodule

FILE: tb/sv/qr_data_mask_apply_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for qr_data_mask_apply. All checking lives in the
// checker instance; this module only drives transactions, pauses for config
// writes and decides pass/fail from the checker's mismatch count.
module qr_data_mask_apply_tb;
    import qrmask_pkg::*;

    localparam int unsigned PHASES        = 16;
    localparam int unsigned PHASE_ITEMS   = 110;
    localparam int unsigned HOLD_CYCLES   = 60;    // long receiver hold-off
    localparam int unsigned SETTLE_CYCLES = 4;     // two-stage pipe plus margin
    localparam int unsigned DRAIN_LIMIT   = 5000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [COORD_W-1:0]   i_row;
    logic [COORD_W-1:0]   i_col;
    logic [MODULE_W-1:0]  i_module_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [MODULE_W-1:0]  o_module_out;
    logic                 o_was_masked;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    logic                 final_check;
    int unsigned          pending;
    int unsigned          mismatch_count;

    // Idling percentages, changed by the stimulus between phases
    int unsigned          tx_idle_pct;
    int unsigned          rx_stall_pct;
    bit                   hold_request;
    logic [VERSION_W-1:0] cur_version;

    qr_data_mask_apply uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_module_in  (i_module_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_module_out (o_module_out),
        .o_was_masked (o_was_masked),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    qr_data_mask_apply_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_module_in      (i_module_in),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_module_out     (o_module_out),
        .o_was_masked     (o_was_masked),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_final_check    (final_check),
        .o_pending        (pending),
        .o_mismatch_count (mismatch_count)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Overall limit: far above the slowest legal run
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Output side: random stall per cycle, or one long hold-off on request.
    // During the hold-off the sender keeps offering, so both stages fill and
    // o_in_stall must come up.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // One module transaction; optional idle gap first, then hold the payload
    // until the block takes it
    task automatic send_module(input logic [COORD_W-1:0] row,
                               input logic [COORD_W-1:0] col,
                               input logic [MODULE_W-1:0] mod_in);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_row       <= row;
        i_col       <= col;
        i_module_in <= mod_in;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Registers only change with the pipe empty: stop offering, let every
    // expected result come out, then give the stages time to settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers back to back; the unused upper data bits of the
    // mask write are random so every data bit toggles
    task automatic set_config(input logic [VERSION_W-1:0] version,
                              input t_mask_sel mask);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_QR_VERSION;
        i_cfg_data  <= version;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_MASK_PATTERN;
        i_cfg_data  <= {3'($urandom_range(7)), mask};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_version = version;
    endtask

    // Mostly coordinates inside the grid, some around its far edge (finder and
    // version-info borders, first outside index), the rest anywhere in 0..255
    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned side);
        int unsigned sel, top, v;
        sel = $urandom_range(99);
        top = (side > 256) ? 255 : side - 1;
        if (sel < 70)
            v = $urandom_range(top, 0);
        else if (sel < 82)
            v = side - 12 + $urandom_range(12);
        else
            v = $urandom_range(255);
        return COORD_W'((v > 255) ? 255 : v);
    endfunction

    // Versions per random phase: limits, out-of-range values and the
    // version-info threshold on both sides
    logic [VERSION_W-1:0] phase_versions [PHASES] = '{
        6'd1, 6'd40, 6'd0, 6'd63, 6'd7, 6'd6, 6'd20, 6'd2,
        6'd40, 6'd13, 6'd7, 6'd27, 6'd63, 6'd0, 6'd1, 6'd55
    };

    initial begin
        int unsigned side;
        int unsigned drain_cycles;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_row        = '0;
        i_col        = '0;
        i_module_in  = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_QR_VERSION;
        i_cfg_data   = '0;
        final_check  = 1'b0;
        hold_request = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        cur_version  = VERSION_RST;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, reset setting: version 1 (side 21), mask 0 ---
        send_module(8'd0,   8'd0,   2'd0);    // top-left finder
        send_module(8'd255, 8'd255, 2'd3);    // all ones, outside
        send_module(8'd20,  8'd20,  2'd1);    // last data corner
        send_module(8'd21,  8'd9,   2'd1);    // first row outside
        send_module(8'd9,   8'd21,  2'd0);    // first column outside
        send_module(8'd6,   8'd10,  2'd1);    // timing row
        send_module(8'd10,  8'd6,   2'd0);    // timing column
        send_module(8'd8,   8'd8,   2'd1);    // top-left finder edge
        send_module(8'd9,   8'd9,   2'd0);    // first data past it
        send_module(8'd13,  8'd8,   2'd1);    // bottom-left finder edge
        send_module(8'd12,  8'd8,   2'd1);    // just above it: data
        send_module(8'd8,   8'd13,  2'd0);    // top-right finder edge
        send_module(8'd8,   8'd12,  2'd1);    // just left of it: data
        send_module(8'd10,  8'd11,  2'd2);    // reserved
        send_module(8'd10,  8'd11,  2'd3);    // reserved
        send_module(8'd128, 8'd127, 2'd1);    // top coordinate bits

        // --- directed, version 7 (side 45): version-info blocks ---
        set_config(6'd7, MASK_PROD_SUM);
        send_module(8'd0,  8'd34, 2'd1);      // top-right block, low corner
        send_module(8'd5,  8'd36, 2'd0);      // top-right block, high corner
        send_module(8'd5,  8'd33, 2'd1);      // just left: data
        send_module(8'd34, 8'd0,  2'd1);      // bottom-left block
        send_module(8'd36, 8'd5,  2'd0);
        send_module(8'd37, 8'd5,  2'd1);      // bottom-left finder
        send_module(8'd33, 8'd5,  2'd1);      // just above the block: data
        send_module(8'd44, 8'd44, 2'd0);      // last corner

        // --- random phases: receiver-heavy idling, then sender-heavy, then none ---
        for (int p = 0; p < PHASES; p++) begin
            set_config(phase_versions[p], t_mask_sel'(p % 8));
            if (p < 6) begin
                tx_idle_pct  = 22;
                rx_stall_pct = 87;
            end else if (p < 11) begin
                tx_idle_pct  = 87;
                rx_stall_pct = 22;
            end else begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            if (p == 12)
                hold_request = 1'b1;
            side = 4 * cur_version + GRID_BASE;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_module(pick_coord(side), pick_coord(side),
                            ($urandom_range(99) < 85) ? MODULE_W'($urandom_range(1))
                                                      : MODULE_W'($urandom_range(3, 2)));
            end
        end

        // --- drain, then ask the checker about leftovers ---
        i_in_valid <= 1'b0;
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        final_check <= 1'b1;
        repeat (2) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
rtl/qrmask_pkg.sv
rtl/qr_data_mask_apply.sv
tb/sv/qr_data_mask_apply_checker.sv
tb/sv/qr_data_mask_apply_tb.sv
